@@ design/lfac_pkg.sv @@
// ----------------------------------------------------------------------------
// lfac_pkg
// shared types and helpers for the fully associative lru cache model
// ----------------------------------------------------------------------------
package lfac_pkg;

    localparam int CNT_WIDTH = 32;
    localparam int CFG_WIDTH = 7;
    localparam int CAP_RESET = 64;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIN  = 4'b0100,
        S_RES  = 4'b1000
    } t_state;

    function automatic logic [CNT_WIDTH-1:0] sat_inc(input logic [CNT_WIDTH-1:0] v);
        logic [CNT_WIDTH-1:0] r;
        r = (v == {CNT_WIDTH{1'b1}}) ? v : v + CNT_WIDTH'(1);
        return r;
    endfunction

endpackage

@@ design/lru_fully_associative_cache_sim.sv @@
// a hit ends the recency scan at the matching position; a miss scans every valid
// position and then inserts, or inserts straight away when the cache is empty
// one item at a time; input is ready again in the cycle after its result is
// registered, and a result waits while the output stalls; the recency scan
// reads one position a cycle through the recency ram and then the address ram
// reset: synchronous active low; cache empties, counters clear, capacity goes to 64
// ----------------------------------------------------------------------------
// lru_fully_associative_cache_sim
// fully associative lru cache lookup with saturating hit and miss counters
// ----------------------------------------------------------------------------
module lru_fully_associative_cache_sim #(
    parameter int ENTRIES    = 64,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [31:0]                     i_address,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_hit,
    output logic [lfac_pkg::CNT_WIDTH-1:0]  o_hit_total,
    output logic [lfac_pkg::CNT_WIDTH-1:0]  o_miss_total,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lfac_pkg::CFG_WIDTH-1:0]  i_cfg_data
);

    import lfac_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    t_state                  r_state;
    logic [CFG_WIDTH-1:0]    r_capacity;
    logic [CW-1:0]           r_occ;
    logic [ADDR_WIDTH-1:0]   r_addr;
    logic                    r_full;
    logic [CW-1:0]           r_rd_pos;
    logic                    r_s1_vld;
    logic [CW-1:0]           r_s1_pos;
    logic                    r_s2_vld;
    logic [CW-1:0]           r_s2_pos;
    logic [IW-1:0]           r_s2_slot;
    logic [IW-1:0]           r_victim;
    logic                    r_hit;
    logic                    r_out_valid;
    logic                    r_out_hit;
    logic [CNT_WIDTH-1:0]    r_hit_total;
    logic [CNT_WIDTH-1:0]    r_miss_total;

    logic [63:0]             w_addr64;
    logic [CW-1:0]           w_cap;
    logic                    w_rd_en;
    logic                    w_match;
    logic                    w_last;
    logic [CW-1:0]           w_pos_inc;
    logic [IW-1:0]           w_new_slot;
    logic                    w_out_free;
    logic                    w_rec_we;
    logic [IW-1:0]           w_rec_waddr;
    logic [IW-1:0]           w_rec_wdata;
    logic [IW-1:0]           w_rec_rdata;
    logic                    w_ent_we;
    logic [ADDR_WIDTH-1:0]   w_ent_rdata;

    assign w_addr64 = {32'd0, i_address};

    // effective capacity clamped to 1..ENTRIES
    always_comb begin
        if (r_capacity == '0) begin
            w_cap = CW'(1);
        end else if (32'(r_capacity) > 32'(ENTRIES)) begin
            w_cap = CW'(ENTRIES);
        end else begin
            w_cap = CW'(r_capacity);
        end
    end

    assign w_rd_en    = (r_state == S_SCAN) && (r_rd_pos < r_occ);
    assign w_match    = (w_ent_rdata == r_addr);
    assign w_last     = (r_s2_pos == (r_occ - CW'(1)));
    assign w_pos_inc  = r_s2_pos + CW'(1);
    // while not full the new entry takes the slot numbered by the occupancy
    assign w_new_slot = r_full ? r_victim : r_occ[IW-1:0];
    assign w_out_free = !r_out_valid || i_out_ready;

    // recency writes: shift one place per missed compare (but the last one when full), front on hit or insert
    always_comb begin
        w_rec_we    = 1'b0;
        w_rec_waddr = '0;
        w_rec_wdata = '0;
        if ((r_state == S_SCAN) && r_s2_vld) begin
            if (w_match) begin
                w_rec_we    = 1'b1;
                w_rec_wdata = r_s2_slot;
            end else if (!(w_last && r_full)) begin
                w_rec_we    = 1'b1;
                w_rec_waddr = w_pos_inc[IW-1:0];
                w_rec_wdata = r_s2_slot;
            end
        end else if (r_state == S_FIN) begin
            w_rec_we    = 1'b1;
            w_rec_wdata = w_new_slot;
        end
    end

    assign w_ent_we = (r_state == S_FIN);

    lfac_ram #(
        .WIDTH (IW),
        .DEPTH (ENTRIES)
    ) u_recency_ram (
        .i_clk   (i_clk),
        .i_we    (w_rec_we),
        .i_waddr (w_rec_waddr),
        .i_wdata (w_rec_wdata),
        .i_raddr (r_rd_pos[IW-1:0]),
        .o_rdata (w_rec_rdata)
    );

    lfac_ram #(
        .WIDTH (ADDR_WIDTH),
        .DEPTH (ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_ent_we),
        .i_waddr (w_new_slot),
        .i_wdata (r_addr),
        .i_raddr (w_rec_rdata),
        .o_rdata (w_ent_rdata)
    );

    // payload of the scan pipeline
    always_ff @(posedge i_clk) begin
        r_s1_pos  <= r_rd_pos;
        r_s2_pos  <= r_s1_pos;
        r_s2_slot <= w_rec_rdata;
        if (r_state == S_IDLE && i_in_valid) begin
            r_addr <= w_addr64[ADDR_WIDTH-1:0];
        end
        if ((r_state == S_SCAN) && r_s2_vld && !w_match && w_last) begin
            r_victim <= r_s2_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_capacity   <= CFG_WIDTH'(CAP_RESET);
            r_occ        <= '0;
            r_full       <= 1'b0;
            r_rd_pos     <= '0;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_hit        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_hit    <= 1'b0;
            r_hit_total  <= '0;
            r_miss_total <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            // in the result state the output register is reloaded below
            if (r_out_valid && i_out_ready && (r_state != S_RES)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_rd_pos <= '0;
                    r_s1_vld <= 1'b0;
                    r_s2_vld <= 1'b0;
                    if (i_in_valid) begin
                        r_full  <= (r_occ >= w_cap);
                        r_state <= (r_occ == '0) ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_s2_vld && w_match) begin
                        r_hit    <= 1'b1;
                        r_s1_vld <= 1'b0;
                        r_s2_vld <= 1'b0;
                        r_state  <= S_RES;
                    end else begin
                        if (w_rd_en) begin
                            r_rd_pos <= r_rd_pos + CW'(1);
                        end
                        r_s1_vld <= w_rd_en;
                        r_s2_vld <= r_s1_vld;
                        if (r_s2_vld && w_last) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_hit <= 1'b0;
                    if (!r_full) begin
                        r_occ <= r_occ + CW'(1);
                    end
                    r_state <= S_RES;
                end
                S_RES: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_hit   <= r_hit;
                        if (r_hit) begin
                            r_hit_total <= sat_inc(r_hit_total);
                        end else begin
                            r_miss_total <= sat_inc(r_miss_total);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_hit_total  = r_hit_total;
    assign o_miss_total = r_miss_total;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_occ) <= 32'(ENTRIES))
        else $error("occupancy above entry count");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_s2_vld) |-> (r_s2_pos < r_occ))
        else $error("compare beyond valid positions");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && !r_full) |-> (32'(r_occ) < 32'(ENTRIES)))
        else $error("insert without a free slot");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1_vld && !r_s2_vld))
        else $error("scan pipeline busy while idle");

    a_count_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && ((r_hit_total != $past(r_hit_total))
            || (r_miss_total != $past(r_miss_total))))
        |-> ($past(r_state) == S_RES))
        else $error("counter changed outside result commit");

endmodule

@@ design/lfac_ram.sv @@
// ----------------------------------------------------------------------------
// lfac_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lfac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ verif/lru_fully_associative_cache_sim_tb.sv @@
// ----------------------------------------------------------------------------
// lru_fully_associative_cache_sim_tb
// self-checking bench for the fully associative lru cache lookup: a queue-fed
// driver offers addresses, a clocked monitor predicts hit flag and running
// totals for every accepted item and compares each result in order
// ----------------------------------------------------------------------------
module lru_fully_associative_cache_sim_tb;

    import lfac_pkg::*;

    localparam int SLOTS        = 64;
    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 80;
    localparam int MAX_PRINTS   = 40;

    typedef struct packed {
        logic                 hit;
        logic [CNT_WIDTH-1:0] hit_total;
        logic [CNT_WIDTH-1:0] miss_total;
    } t_lookup_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic [31:0]           i_address   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_hit;
    logic [CNT_WIDTH-1:0]  o_hit_total;
    logic [CNT_WIDTH-1:0]  o_miss_total;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_WIDTH-1:0]  i_cfg_data;

    lru_fully_associative_cache_sim DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_address    (i_address),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit        (o_hit),
        .o_hit_total  (o_hit_total),
        .o_miss_total (o_miss_total),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // predicted cache contents
    logic [31:0]          slot_addr [SLOTS];
    int unsigned          lru_slot [SLOTS];
    int unsigned          fill;
    logic [CNT_WIDTH-1:0] hits;
    logic [CNT_WIDTH-1:0] misses;
    logic [CFG_WIDTH-1:0] cap_reg;

    t_lookup_result pending_lookups[$];
    t_lookup_result oldest;
    logic [31:0]    addr_queue[$];
    logic [31:0]    addr_pool[$];

    int  err_count    = 0;
    int  quiet_cycles = 0;
    bit  in_fired     = 1'b0;
    bit  cfg_fired    = 1'b0;
    bit  idle_on      = 1'b1;
    int  src_gap      = 0;
    int  sink_gap     = 0;
    int  hold_left    = 0;
    int  hold_asked   = 0;
    int  hold_done    = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        if (err_count < MAX_PRINTS) begin
            $display("error: %s", msg);
        end
        err_count++;
    endtask

    task automatic cache_reset();
        for (int i = 0; i < SLOTS; i++) begin
            slot_addr[i] = '0;
            lru_slot[i]  = i;
        end
        fill    = 0;
        hits    = '0;
        misses  = '0;
        cap_reg = CFG_WIDTH'(CAP_RESET);
    endtask

    task automatic move_to_front(input int unsigned pos);
        int unsigned slot;
        slot = lru_slot[pos];
        for (int unsigned p = pos; p > 0; p--) begin
            lru_slot[p] = lru_slot[p-1];
        end
        lru_slot[0] = slot;
    endtask

    task automatic predict_lookup(input logic [31:0] addr);
        int unsigned    cap;
        int unsigned    found;
        bit             hit;
        t_lookup_result r;
        cap = cap_reg;
        if (cap < 1) cap = 1;
        if (cap > SLOTS) cap = SLOTS;
        hit   = 1'b0;
        found = 0;
        // search every valid entry, even above a lowered capacity
        for (int unsigned pos = 0; pos < fill; pos++) begin
            if (!hit && slot_addr[lru_slot[pos]] == addr) begin
                hit   = 1'b1;
                found = pos;
            end
        end
        if (hit) begin
            move_to_front(found);
            hits = (hits == '1) ? hits : hits + 1'b1;
        end else begin
            // at or over capacity the least recent slot is reused
            if (fill >= cap) begin
                move_to_front(fill - 1);
            end else begin
                move_to_front(fill);
                fill++;
            end
            slot_addr[lru_slot[0]] = addr;
            misses = (misses == '1) ? misses : misses + 1'b1;
        end
        r.hit        = hit;
        r.hit_total  = hits;
        r.miss_total = misses;
        pending_lookups.push_back(r);
    endtask

    // driver: one item at a time from addr_queue
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fired) begin
            // hold until accepted
        end else if (src_gap > 0) begin
            i_in_valid <= 1'b0;
            src_gap = src_gap - 1;
        end else if (addr_queue.size() > 0) begin
            i_in_valid <= 1'b1;
            i_address  <= addr_queue.pop_front();
            if (idle_on && $urandom_range(0, 3) == 0) begin
                src_gap = $urandom_range(1, 18);
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // receiver: random stall bursts plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            hold_left = LONG_HOLD - 1;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap = sink_gap - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(1, 18) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor: predict on accepted items, check accepted results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_fired     <= 1'b0;
            cfg_fired    <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            in_fired  <= i_in_valid && o_in_ready;
            cfg_fired <= i_cfg_valid && o_cfg_ready;
            if (i_cfg_valid && o_cfg_ready) begin
                cap_reg = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                predict_lookup(i_address);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_lookups.size() == 0) begin
                    flag_error($sformatf("result with no lookup pending: hit %b hits %0d misses %0d",
                                         o_hit, o_hit_total, o_miss_total));
                end else begin
                    oldest = pending_lookups.pop_front();
                    if (o_hit !== oldest.hit)
                        flag_error($sformatf("hit: got %b, expected %b", o_hit, oldest.hit));
                    if (o_hit_total !== oldest.hit_total)
                        flag_error($sformatf("hit_total: got %0d, expected %0d",
                                             o_hit_total, oldest.hit_total));
                    if (o_miss_total !== oldest.miss_total)
                        flag_error($sformatf("miss_total: got %0d, expected %0d",
                                             o_miss_total, oldest.miss_total));
                end
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [31:0] fresh_address();
        logic [31:0] a;
        case ($urandom_range(0, 19))
            0:       a = 32'h0000_0000;
            1:       a = 32'hFFFF_FFFF;
            default: a = $urandom;
        endcase
        return a;
    endfunction

    task automatic write_capacity(input logic [CFG_WIDTH-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(negedge i_clk); while (!cfg_fired);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (addr_queue.size() != 0 || i_in_valid || pending_lookups.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // keep part of the old working set so lookups also land on older entries
    task automatic build_pool(input int n);
        logic [31:0] kept[$];
        foreach (addr_pool[i]) begin
            if (kept.size() < n / 2 && $urandom_range(0, 1) == 1)
                kept.push_back(addr_pool[i]);
        end
        while (kept.size() < n) kept.push_back(fresh_address());
        addr_pool = kept;
    endtask

    task automatic run_phase(input logic [CFG_WIDTH-1:0] cap, input int items,
                             input int pool_n, input bit long_hold, input bit pause_mid);
        write_capacity(cap);
        build_pool(pool_n);
        if (long_hold) hold_asked++;
        for (int i = 0; i < items; i++) begin
            if (pause_mid && i == items / 2) wait_drained();
            if ($urandom_range(0, 99) < 85)
                addr_queue.push_back(addr_pool[$urandom_range(0, addr_pool.size() - 1)]);
            else
                addr_queue.push_back(fresh_address());
        end
        wait_drained();
    endtask

    initial begin
        int unsigned c;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        cache_reset();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme addresses, hits at several depths
        addr_queue = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
                       32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 32'h8000_0000,
                       32'h0000_0001, 32'hAAAA_AAAA};
        wait_drained();
        // zero capacity acts as one, and sits below the current occupancy
        write_capacity(7'd0);
        addr_queue = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678, 32'h1234_5678,
                       32'h5555_5555};
        wait_drained();
        // capacity above the entry count acts as the entry count
        write_capacity(7'd127);
        addr_queue = '{32'hDEAD_BEEF, 32'h0000_FFFF, 32'hFFFF_0000, 32'hDEAD_BEEF};
        wait_drained();

        // full cache with evictions, under a long receiver hold and a sender pause
        run_phase(7'd127, 130, 80, 1'b1, 1'b1);
        run_phase(7'd0,    30,  4, 1'b0, 1'b0);
        run_phase(7'd1,    25,  3, 1'b0, 1'b0);
        c = $urandom_range(2, 63);
        run_phase(CFG_WIDTH'(c), 40, c + 4, 1'b0, 1'b0);
        run_phase(7'd8,    35, 10, 1'b0, 1'b0);
        c = $urandom_range(0, 127);
        run_phase(CFG_WIDTH'(c), 40, ((c < 1) ? 1 : (c > SLOTS) ? SLOTS : c) + 5,
                  1'b0, 1'b0);
        run_phase(7'd64,   40, 50, 1'b0, 1'b0);
        idle_on = 1'b0;
        run_phase(7'd3,    30,  5, 1'b0, 1'b0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_lookups.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_lookups.size()));
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
